// ===== src/ccav_pkg.sv =====
package ccav_pkg;

	// CRC width select codes; the unused code behaves as 32 bits
	localparam logic [1:0] WSEL_8  = 2'd0;
	localparam logic [1:0] WSEL_16 = 2'd1;
	localparam logic [1:0] WSEL_32 = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH_SEL = 2'd0;
	localparam logic [1:0] REG_POLY      = 2'd1;
	localparam logic [1:0] REG_INIT      = 2'd2;

	localparam logic [1:0]  WSEL_RESET = WSEL_32;
	localparam logic [31:0] POLY_RESET = 32'h04C1_1DB7;
	localparam logic [15:0] INIT_RESET = 16'h0000;

	localparam logic [2:0] CNT_SAT = 3'd5;

	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 48;

endpackage

// ===== src/ccav_crc_byte.sv =====
module ccav_crc_byte (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	input  logic [1:0]  wsel,
	input  logic [31:0] poly,
	output logic [31:0] crc_out
);

	logic [4:0]  shamt;
	logic [31:0] mask;
	logic [31:0] regl;
	logic [31:0] polyl;

	// left-justify the register so the feedback tap is always bit 31
	always_comb begin
		unique case (wsel)
			ccav_pkg::WSEL_8: begin
				shamt = 5'd24;
				mask  = 32'h0000_00FF;
			end
			ccav_pkg::WSEL_16: begin
				shamt = 5'd16;
				mask  = 32'h0000_FFFF;
			end
			default: begin
				shamt = 5'd0;
				mask  = 32'hFFFF_FFFF;
			end
		endcase
		polyl = (poly & mask) << shamt;
		regl  = ((crc_in & mask) << shamt) ^ {data, 24'h00_0000};
		for (int i = 0; i < 8; i++) begin
			if (regl[31]) begin
				regl = (regl << 1) ^ polyl;
			end else begin
				regl = regl << 1;
			end
		end
		crc_out = regl >> shamt;
	end

endmodule

// ===== src/configurable_crc_append_verify.sv =====
// Words pass the input stage, then the output register. Throughput: one
// word per cycle while m_axis is ready; on the last word of a generate frame
// the input stalls while 1, 2 or 4 CRC words drain from the output register.
// Reset (arst_n low, asynchronous): both stages empty, CRC state cleared,
// next word starts a frame, configuration back to 32-bit CRC, 0x04C11DB7, 0.
module configurable_crc_append_verify (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [ccav_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
	input  logic                           s_axis_tlast,  // last_byte
	input  logic [0:0]                     s_axis_tuser,  // [0] mode
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] out_byte, [39:8] crc_value, [40] frame_ok, [47:41] zero
	output logic [ccav_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast,  // last_of_run
	output logic [0:0]                     m_axis_tuser   // [0] is_crc_byte
);

	logic [1:0]  wsel_q;
	logic [31:0] poly_q;
	logic [15:0] init_q;

	logic [31:0] crc_q;
	logic [2:0]  cnt_q;
	logic        start_q;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        mode_s1;

	logic        m_valid_q;
	logic [2:0]  crc_left_q;
	logic [7:0]  m_byte_q;
	logic        m_is_crc_q;
	logic [31:0] m_crc_q;
	logic        m_ok_q;
	logic        m_last_q;

	logic        load_out;
	logic        adv;
	logic        emit_crc;
	logic [31:0] crc_base;
	logic [31:0] crc_new;
	logic [2:0]  cnt_base;
	logic [2:0]  cnt_new;
	logic [2:0]  nbytes;
	logic [1:0]  byte_sel;
	logic [7:0]  crc_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsel_q <= ccav_pkg::WSEL_RESET;
			poly_q <= ccav_pkg::POLY_RESET;
			init_q <= ccav_pkg::INIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ccav_pkg::REG_WIDTH_SEL: wsel_q <= cfg_data[1:0];
				ccav_pkg::REG_POLY:      poly_q <= cfg_data;
				ccav_pkg::REG_INIT:      init_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign load_out      = !m_valid_q || (m_axis_tready && crc_left_q == 3'd0);
	assign adv           = valid_s1 && load_out;
	assign s_axis_tready = !valid_s1 || load_out;
	assign emit_crc      = m_valid_q && m_axis_tready && crc_left_q != 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
			mode_s1 <= s_axis_tuser[0];
		end
	end

	always_comb begin
		unique case (wsel_q)
			ccav_pkg::WSEL_8:  nbytes = 3'd1;
			ccav_pkg::WSEL_16: nbytes = 3'd2;
			default:           nbytes = 3'd4;
		endcase
		crc_base = start_q ? {16'h0000, init_q} : crc_q;
		cnt_base = start_q ? 3'd0 : cnt_q;
		cnt_new  = (cnt_base == ccav_pkg::CNT_SAT) ? ccav_pkg::CNT_SAT : cnt_base + 3'd1;
	end

	ccav_crc_byte u_crc (
		.crc_in  (crc_base),
		.data    (data_s1),
		.wsel    (wsel_q),
		.poly    (poly_q),
		.crc_out (crc_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= '0;
			cnt_q   <= '0;
			start_q <= 1'b1;
		end else if (adv) begin
			crc_q   <= crc_new;
			cnt_q   <= cnt_new;
			start_q <= last_s1;
		end
	end

	// CRC bytes go out most significant first
	assign byte_sel = 2'(crc_left_q - 3'd1);
	always_comb begin
		unique case (byte_sel)
			2'd0: crc_byte = m_crc_q[7:0];
			2'd1: crc_byte = m_crc_q[15:8];
			2'd2: crc_byte = m_crc_q[23:16];
			default: crc_byte = m_crc_q[31:24];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			crc_left_q <= '0;
		end else if (load_out) begin
			m_valid_q  <= valid_s1;
			crc_left_q <= (adv && last_s1 && !mode_s1) ? nbytes : 3'd0;
		end else if (emit_crc) begin
			crc_left_q <= crc_left_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_byte_q   <= data_s1;
			m_is_crc_q <= 1'b0;
			m_crc_q    <= crc_new;
			m_ok_q     <= last_s1 && mode_s1 && (cnt_new > nbytes) && (crc_new == 32'h0);
			m_last_q   <= last_s1 && mode_s1;
		end else if (emit_crc) begin
			m_byte_q   <= crc_byte;
			m_is_crc_q <= 1'b1;
			m_ok_q     <= 1'b0;
			m_last_q   <= (crc_left_q == 3'd1);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_ok_q, m_crc_q, m_byte_q};
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_is_crc_q;

	a_left_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		crc_left_q != 3'd0 |-> m_valid_q)
		else $error("CRC bytes pending with empty output register");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		crc_left_q <= 3'd4)
		else $error("CRC byte counter out of range");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(data_s1) && $stable(last_s1))
		else $error("input stage lost a stalled word");

	a_crc_word_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_is_crc_q |-> !m_ok_q)
		else $error("verdict set on an appended CRC word");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(crc_q) && $stable(cnt_q))
		else $error("CRC state changed without a word advancing");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam logic [1:0] WSEL_UNUSED = 2'd3;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       mode;
	} frame_word_t;

	typedef struct {
		logic [7:0]  out_byte;
		logic        is_crc;
		logic [31:0] crc;
		logic        ok;
		logic        last;
	} crc_word_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [1:0]                      cfg_index = '0;
	logic [31:0]                     cfg_data = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [ccav_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] data_byte
	logic                            s_axis_tlast = 1'b0; // last_byte
	logic [0:0]                      s_axis_tuser = '0;   // [0] mode
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	// [7:0] out_byte, [39:8] crc_value, [40] frame_ok, [47:41] zero
	logic [ccav_pkg::M_TDATA_W-1:0]  m_axis_tdata;
	logic                            m_axis_tlast;        // last_of_run
	logic [0:0]                      m_axis_tuser;        // [0] is_crc_byte

	// model of configuration and CRC state
	logic [1:0]  cfg_wsel = ccav_pkg::WSEL_RESET;
	logic [31:0] cfg_poly = ccav_pkg::POLY_RESET;
	logic [15:0] cfg_init = ccav_pkg::INIT_RESET;
	logic [31:0] crc_state = '0;
	logic [2:0]  byte_cnt = '0;
	logic        frame_start = 1'b1;

	frame_word_t byte_queue[$];
	crc_word_t   expected_words[$];

	int  mismatch_count = 0;
	int  words_queued = 0;
	int  words_in = 0;
	int  words_out = 0;
	int  frames_queued = 0;
	int  settings_used = 1;
	int  src_gap = 0;
	int  snk_gap = 0;
	int  hold_cnt = 0;
	int  stall_len = 0;
	bit  stall_req = 0;
	bit  idle_en = 1;

	configurable_crc_append_verify uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("configurable_crc_append_verify test failed");
		$finish;
	end

	function automatic int width_of(logic [1:0] wsel);
		if (wsel == ccav_pkg::WSEL_8) return 8;
		if (wsel == ccav_pkg::WSEL_16) return 16;
		return 32;
	endfunction

	// one byte through the MSB-first LFSR, register masked to the width
	function automatic logic [31:0] crc_byte(logic [31:0] r, logic [7:0] b,
			logic [1:0] wsel, logic [31:0] poly);
		int w;
		logic [31:0] mask;
		logic [31:0] top;
		w = width_of(wsel);
		mask = (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
		top = 32'h1 << (w - 1);
		r = (r & mask) ^ ({24'h0, b} << (w - 8));
		for (int i = 0; i < 8; i++) begin
			if ((r & top) != 0)
				r = ((r << 1) ^ (poly & mask)) & mask;
			else
				r = (r << 1) & mask;
		end
		return r;
	endfunction

	task automatic predict_word(logic [7:0] b, logic lst, logic md);
		int nb;
		crc_word_t e;
		if (frame_start) begin
			crc_state = {16'h0, cfg_init};
			byte_cnt = '0;
			frame_start = 1'b0;
		end
		crc_state = crc_byte(crc_state, b, cfg_wsel, cfg_poly);
		if (byte_cnt < ccav_pkg::CNT_SAT)
			byte_cnt = byte_cnt + 3'd1;
		nb = width_of(cfg_wsel) / 8;
		e.out_byte = b;
		e.is_crc = 1'b0;
		e.crc = crc_state;
		e.ok = 1'b0;
		e.last = 1'b0;
		if (lst) begin
			frame_start = 1'b1;
			if (md) begin
				e.ok = (byte_cnt > nb) && (crc_state == 32'h0);
				e.last = 1'b1;
				expected_words.push_back(e);
			end else begin
				expected_words.push_back(e);
				for (int i = 0; i < nb; i++) begin
					e.out_byte = crc_state[8 * (nb - 1 - i) +: 8];
					e.is_crc = 1'b1;
					e.last = (i == nb - 1);
					expected_words.push_back(e);
				end
			end
		end else begin
			expected_words.push_back(e);
		end
	endtask

	task automatic push_word(logic [7:0] b, logic lst, logic md);
		frame_word_t it;
		it.data = b;
		it.last = lst;
		it.mode = md;
		byte_queue.push_back(it);
		words_queued++;
		if (lst)
			frames_queued++;
	endtask

	// data bytes, then for verify frames the trailing CRC (right or random)
	task automatic push_frame(int data_len, bit vfy, bit good);
		logic [31:0] r;
		logic [7:0] b;
		int nb;
		r = {16'h0, cfg_init};
		nb = width_of(cfg_wsel) / 8;
		for (int i = 0; i < data_len; i++) begin
			b = 8'($urandom_range(0, 255));
			r = crc_byte(r, b, cfg_wsel, cfg_poly);
			if (!vfy && i == data_len - 1)
				push_word(b, 1'b1, 1'b0);
			else
				push_word(b, 1'b0, 1'($urandom_range(0, 1)));
		end
		if (vfy) begin
			for (int i = 0; i < nb; i++) begin
				b = good ? r[8 * (nb - 1 - i) +: 8] : 8'($urandom_range(0, 255));
				if (i == nb - 1)
					push_word(b, 1'b1, 1'b1);
				else
					push_word(b, 1'b0, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic random_frame();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			push_frame($urandom_range(1, 9), 1'b0, 1'b0);
		else if (sel < 8)
			push_frame($urandom_range(1, 6), 1'b1, 1'b1);
		else if (sel == 8)
			push_frame(0, 1'b1, 1'b1);
		else
			push_frame($urandom_range(0, 5), 1'b1, 1'b0);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			ccav_pkg::REG_WIDTH_SEL: cfg_wsel = val[1:0];
			ccav_pkg::REG_POLY:      cfg_poly = val;
			ccav_pkg::REG_INIT:      cfg_init = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (byte_queue.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin : stim
		logic [1:0]  w;
		logic [31:0] poly;
		logic [15:0] init;
		int start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: 32-bit CRC
		push_word(8'hFF, 1'b1, 1'b0);
		push_word(8'h00, 1'b0, 1'b1);
		push_word(8'h80, 1'b0, 1'b0);
		push_word(8'h7F, 1'b1, 1'b0);
		push_frame(1, 1'b1, 1'b1);
		for (int i = 0; i < 4; i++)
			push_word(8'h00, i == 3, 1'b1);
		push_frame(1, 1'b1, 1'b0);
		push_word(8'hA5, 1'b0, 1'b0);
		push_word(8'h5A, 1'b0, 1'b1);
		wait_idle();
		// width change in the middle of a frame
		write_reg(ccav_pkg::REG_WIDTH_SEL, {30'h0, ccav_pkg::WSEL_8});
		settings_used++;
		push_word(8'hC3, 1'b0, 1'b0);
		push_word(8'h3C, 1'b1, 1'b0);
		push_word(8'h00, 1'b1, 1'b1);
		push_frame(1, 1'b1, 1'b1);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin w = ccav_pkg::WSEL_8; poly = 32'h0000_0007; init = 16'hFFFF; end
				1: begin w = ccav_pkg::WSEL_16; poly = 32'h0000_1021; init = 16'hFFFF; end
				2: begin w = WSEL_UNUSED; poly = 32'hFFFF_FFFF; init = 16'h0000; end
				3: begin w = ccav_pkg::WSEL_8; poly = 32'hFFFF_FFFF; init = 16'($urandom); end
				4: begin w = ccav_pkg::WSEL_32; poly = 32'h0000_0000; init = 16'($urandom); end
				default: begin
					w = 2'($urandom_range(0, 3));
					poly = $urandom;
					init = 16'($urandom);
				end
			endcase
			if (p == 5)
				idle_en = 0;
			write_reg(ccav_pkg::REG_WIDTH_SEL, {30'h0, w});
			write_reg(ccav_pkg::REG_POLY, poly);
			write_reg(ccav_pkg::REG_INIT, {16'h0, init});
			settings_used++;
			start = words_queued;
			while (words_queued - start < 30)
				random_frame();
			if (p == 1) begin
				stall_len = 300;
				stall_req = 1;
			end
			wait_idle();
		end

		repeat (6) @(negedge clk);
		$display("covered %0d input words in %0d frames over %0d register settings",
			words_in, frames_queued, settings_used);
		$display("checked %0d output words, %0d mismatches", words_out, mismatch_count);
		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("configurable_crc_append_verify test passed");
		end else begin
			$display("configurable_crc_append_verify test failed");
		end
		$finish;
	end

	always @(posedge clk) begin : driver
		frame_word_t it;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_word(s_axis_tdata, s_axis_tlast, s_axis_tuser[0]);
				words_in++;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (idle_en && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(0, 17);
					s_axis_tvalid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					it = byte_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= it.data;
					s_axis_tlast <= it.last;
					s_axis_tuser <= it.mode;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : sink
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else if (stall_req) begin
				hold_cnt = stall_len - 1;
				stall_req = 0;
				m_axis_tready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				m_axis_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				snk_gap = $urandom_range(0, 17);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		crc_word_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_out++;
			if (expected_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected output word: tdata %h tuser %b tlast %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				e = expected_words.pop_front();
				if (m_axis_tdata[7:0] !== e.out_byte || m_axis_tuser[0] !== e.is_crc ||
						m_axis_tdata[39:8] !== e.crc || m_axis_tdata[40] !== e.ok ||
						m_axis_tlast !== e.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"word %0d mismatch: exp byte %h crc_flag %b crc %h ok %b last %b, ",
							"got byte %h crc_flag %b crc %h ok %b last %b"},
							words_out, e.out_byte, e.is_crc, e.crc, e.ok, e.last,
							m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[39:8],
							m_axis_tdata[40], m_axis_tlast);
				end
			end
		end
	end

endmodule

// ===== filelist.f =====
src/ccav_pkg.sv
src/ccav_crc_byte.sv
src/configurable_crc_append_verify.sv
tb/testbench.sv
